[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define APMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define APMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also checks across reset.
`define APMS_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/apms_pkg.sv]
// Types, codes and constants of the playback mode stream unit.
// No dependencies; used by every module of the block.
package apms_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned WORD_W          = 16;
    localparam int unsigned DLEN_W          = 17;
    localparam int unsigned DELAY_DEPTH_DEF = 65536;
    localparam logic [DLEN_W-1:0] DELAY_RESET = 17'd44100;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_HALF   = 2'd2,
        MODE_DELAY  = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_MODE         = 1'b0,
        CFG_DELAY_LENGTH = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        OP_EMIT    = 2'd0,  // one word, last set
        OP_TWICE   = 2'd1,  // same word twice
        OP_RING_RD = 2'd2,  // emit stored word, advance
        OP_RING_RW = 2'd3   // emit stored word, store new word, advance
    } t_cmd_op;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_FETCH,
        BK_TWICE
    } t_back_state;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] low_byte;
        logic [BYTE_W-1:0] high_byte;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_out_item;

    typedef struct packed {
        t_cmd_op           op;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic cmd_pop;
    } t_back_status;

endpackage

[hdl/apms_front.sv]
// Front part: accepts input items, tracks stereo phase and skip parity,
// and queues commands for the back part. Depends on apms_pkg.
module apms_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  apms_pkg::t_in_item    i_in,
    input  apms_pkg::t_mode       i_mode,
    input  apms_pkg::t_back_status i_status,
    output logic                  o_cmd_valid,
    output apms_pkg::t_cmd        o_cmd
);

    logic           r_right_phase, n_right_phase;
    logic           r_skip_parity, n_skip_parity;
    apms_pkg::t_cmd r_q [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    logic           accept;
    logic           drop;
    logic           enq;
    apms_pkg::t_cmd cmd;
    logic [apms_pkg::WORD_W-1:0] in_word;

    assign full    = (r_cnt == 2'd2) || i_status.clearing;
    assign accept  = push && !full;
    assign in_word = {i_in.high_byte, i_in.low_byte};
    assign enq     = accept && !drop;

    always_comb begin
        n_right_phase = r_right_phase;
        n_skip_parity = r_skip_parity;
        drop          = 1'b0;
        cmd.op        = apms_pkg::OP_EMIT;
        cmd.word      = in_word;
        if (i_in.func) begin
            // drain tick: zero in a left slot, ring tail in a right slot
            n_right_phase = !r_right_phase;
            if (r_right_phase) begin
                cmd.op = apms_pkg::OP_RING_RD;
            end else begin
                cmd.word = '0;
            end
        end else begin
            unique case (i_mode)
                apms_pkg::MODE_DOUBLE: begin
                    n_skip_parity = !r_skip_parity;
                    drop          = r_skip_parity;
                end
                apms_pkg::MODE_HALF: begin
                    cmd.op = apms_pkg::OP_TWICE;
                end
                apms_pkg::MODE_DELAY: begin
                    n_right_phase = !r_right_phase;
                    if (r_right_phase) begin
                        cmd.op = apms_pkg::OP_RING_RW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_phase <= 1'b0;
            r_skip_parity <= 1'b0;
            r_wr          <= 1'b0;
            r_rd          <= 1'b0;
            r_cnt         <= 2'd0;
        end else begin
            if (accept) begin
                r_right_phase <= n_right_phase;
                r_skip_parity <= n_skip_parity;
            end
            if (enq) begin
                r_wr <= !r_wr;
            end
            if (i_status.cmd_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(enq) - 2'(i_status.cmd_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr] <= cmd;
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

endmodule

[hdl/apms_back.sv]
// Back part: runs queued commands against the delay ring memory and
// feeds a two-entry result queue. Depends on apms_pkg.
module apms_back #(
    parameter int unsigned DELAY_DEPTH = apms_pkg::DELAY_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [apms_pkg::DLEN_W-1:0]   i_delay_length,
    input  logic                          i_cmd_valid,
    input  apms_pkg::t_cmd                i_cmd,
    output apms_pkg::t_back_status        o_status,
    output logic                          empty,
    input  logic                          pop,
    output apms_pkg::t_out_item           o_out
);

    localparam int unsigned PW = $clog2(DELAY_DEPTH);
    localparam int unsigned LW = $clog2(DELAY_DEPTH + 1);
    localparam int unsigned CW = (LW > apms_pkg::DLEN_W) ? LW : apms_pkg::DLEN_W;

    apms_pkg::t_back_state r_state, n_state;

    logic [apms_pkg::WORD_W-1:0] r_mem [DELAY_DEPTH];
    logic [apms_pkg::WORD_W-1:0] r_rdata;
    logic [PW-1:0]               r_ptr;
    logic [PW-1:0]               r_clr;
    logic [LW-1:0]               r_len;

    apms_pkg::t_out_item r_oq [2];
    logic                r_owr, r_ord;
    logic [1:0]          r_ocnt;

    logic                space;
    logic                res_push;
    apms_pkg::t_out_item res_item;
    logic                cmd_pop;
    logic                rd_en;
    logic                wr_en;
    logic [PW-1:0]       wr_addr;
    logic [apms_pkg::WORD_W-1:0] wr_data;
    logic                ptr_adv;
    logic                out_pop;
    logic [CW-1:0]       dl;
    logic [PW:0]         ptr_inc;

    assign space   = (r_ocnt != 2'd2);
    assign out_pop = pop && !empty;
    assign dl      = CW'(i_delay_length);
    assign ptr_inc = {1'b0, r_ptr} + (PW+1)'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apms_pkg::BK_CLEAR: begin
                if (r_clr == PW'(DELAY_DEPTH - 1)) begin
                    n_state = apms_pkg::BK_IDLE;
                end
            end
            apms_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        apms_pkg::OP_TWICE: begin
                            if (space) begin
                                n_state = apms_pkg::BK_TWICE;
                            end
                        end
                        apms_pkg::OP_RING_RD,
                        apms_pkg::OP_RING_RW: n_state = apms_pkg::BK_FETCH;
                        default: begin
                        end
                    endcase
                end
            end
            apms_pkg::BK_FETCH,
            apms_pkg::BK_TWICE: begin
                if (space) begin
                    n_state = apms_pkg::BK_IDLE;
                end
            end
            default: n_state = apms_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        res_push      = 1'b0;
        res_item.word = i_cmd.word;
        res_item.last = 1'b1;
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = r_ptr;
        wr_data       = i_cmd.word;
        ptr_adv       = 1'b0;
        unique case (r_state)
            apms_pkg::BK_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = '0;
            end
            apms_pkg::BK_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        apms_pkg::OP_EMIT: begin
                            res_push = space;
                            cmd_pop  = space;
                        end
                        apms_pkg::OP_TWICE: begin
                            res_push      = space;
                            res_item.last = 1'b0;
                        end
                        default: rd_en = 1'b1;
                    endcase
                end
            end
            apms_pkg::BK_FETCH: begin
                res_item.word = r_rdata;
                if (space) begin
                    res_push = 1'b1;
                    cmd_pop  = 1'b1;
                    ptr_adv  = 1'b1;
                    wr_en    = (i_cmd.op == apms_pkg::OP_RING_RW);
                end
            end
            apms_pkg::BK_TWICE: begin
                res_push = space;
                cmd_pop  = space;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apms_pkg::BK_CLEAR;
            r_clr   <= '0;
            r_ptr   <= '0;
            r_owr   <= 1'b0;
            r_ord   <= 1'b0;
            r_ocnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == apms_pkg::BK_CLEAR) begin
                r_clr <= r_clr + PW'(1);
            end
            if (ptr_adv) begin
                // wrap at the ring length in force now
                if (ptr_inc >= (PW+1)'(r_len)) begin
                    r_ptr <= '0;
                end else begin
                    r_ptr <= ptr_inc[PW-1:0];
                end
            end
            if (res_push) begin
                r_owr <= !r_owr;
            end
            if (out_pop) begin
                r_ord <= !r_ord;
            end
            r_ocnt <= r_ocnt + 2'(res_push) - 2'(out_pop);
        end
    end

    // clamp ring length to one .. DELAY_DEPTH
    always_ff @(posedge i_clk) begin
        if (dl == '0) begin
            r_len <= LW'(1);
        end else if (dl > CW'(DELAY_DEPTH)) begin
            r_len <= LW'(DELAY_DEPTH);
        end else begin
            r_len <= LW'(dl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_oq[r_owr] <= res_item;
        end
    end

    assign empty             = (r_ocnt == 2'd0);
    assign o_out             = r_oq[r_ord];
    assign o_status.clearing = (r_state == apms_pkg::BK_CLEAR);
    assign o_status.cmd_pop  = cmd_pop;

endmodule

[hdl/audio_playback_mode_stream_unit.sv]
// Top level of the playback mode stream unit: configuration registers,
// front and back parts. Depends on apms_pkg, apms_front, apms_back.
//
// Input queue side: drive i_in and raise push; the item is taken at an edge
// where push is high and full is low. func selects an audio word
// (low_byte first, high_byte second) or a drain tick for the delay tail.
// Result queue side: while empty is low the oldest result sits on o_out;
// raise pop to take it. last marks the final word caused by one item.
// Configuration: i_cfg_index/i_cfg_data, taken when i_cfg_valid is high
// (o_cfg_ready is always high); write only while the block is idle.
// Path: a taken item is written into the command queue, then its result into
// the result queue; words from the delay ring also pass the registered ring read.
// Throughput: one item a cycle for single-result items while results are taken;
// half speed items, delay right words and right-slot drain ticks also pass through
// BK_TWICE or BK_FETCH, set by the result write port and the registered ring memory read.
// Reset: queues empty, state cleared, then the ring memory is zeroed one
// entry a cycle, every entry, with full held high until the clear ends.
// A stalled receiver fills the two-entry result queue, then the two-entry
// command queue, after which full rises; nothing is lost.
module audio_playback_mode_stream_unit #(
    parameter int unsigned DELAY_DEPTH = apms_pkg::DELAY_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  apms_pkg::t_in_item          i_in,
    output logic                        empty,
    input  logic                        pop,
    output apms_pkg::t_out_item         o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  apms_pkg::t_cfg_index        i_cfg_index,
    input  logic [apms_pkg::DLEN_W-1:0] i_cfg_data
);

    apms_pkg::t_mode              r_mode;
    logic [apms_pkg::DLEN_W-1:0]  r_delay_length;
    logic                         cmd_valid;
    apms_pkg::t_cmd               cmd;
    apms_pkg::t_back_status       status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= apms_pkg::MODE_NORMAL;
            r_delay_length <= apms_pkg::DELAY_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                apms_pkg::CFG_MODE:         r_mode <= apms_pkg::t_mode'(i_cfg_data[1:0]);
                apms_pkg::CFG_DELAY_LENGTH: r_delay_length <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    apms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .i_mode      (r_mode),
        .i_status    (status),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    apms_back #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_delay_length (r_delay_length),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_status       (status),
        .empty          (empty),
        .pop            (pop),
        .o_out          (o_out)
    );

endmodule

[hdl/apms_checker.sv]
// Port-level checks of the playback mode stream unit, bound to the top.
// Depends on apms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module apms_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input apms_pkg::t_out_item o_out
);

    // reset empties the result queue and starts the memory clear
    `APMS_ASSERT_NEXT_ANY(a_reset_state, i_clk, !i_rst_n, full && empty)

    // a waiting result holds while not taken
    `APMS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out))

    // the second half-speed word follows its first without a gap
    `APMS_ASSERT_NEXT(a_pair_follows, i_clk, i_rst_n, !empty && pop && !o_out.last, !empty)

    // the second of a pair carries last and repeats the word
    `APMS_ASSERT_NEXT(a_pair_word, i_clk, i_rst_n, !empty && pop && !o_out.last,
        o_out.last && (o_out.word == $past(o_out.word)))

endmodule

bind audio_playback_mode_stream_unit apms_checker u_apms_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

[dv/audio_playback_mode_stream_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for the playback mode stream unit: a directed table, then random phases.
// Depends on apms_pkg and audio_playback_mode_stream_unit.
module audio_playback_mode_stream_unit_tb;
    import apms_pkg::*;

    localparam int unsigned HOLD_MAX      = 15;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned N_PHASES      = 12;
    localparam int unsigned PHASE_ITEMS   = 112;
    localparam int unsigned RING_DEPTH    = DELAY_DEPTH_DEF;

    typedef struct packed {
        t_mode             mode;
        logic [DLEN_W-1:0] dlen;
        t_in_item          item;
        logic              known;
        logic [1:0]        n_words;
        logic [WORD_W-1:0] word;
    } t_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    t_in_item            i_in        = '0;
    logic                empty;
    logic                pop         = 1'b0;
    t_out_item           o_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    t_cfg_index          i_cfg_index = CFG_MODE;
    logic [DLEN_W-1:0]   i_cfg_data  = '0;

    // Predictor state
    logic [WORD_W-1:0]   delay_ring [0:RING_DEPTH-1];
    int unsigned         ring_ptr    = 0;
    logic                ch_right    = 1'b0;
    logic                skip_next   = 1'b0;
    t_mode               set_mode    = MODE_NORMAL;
    logic [DLEN_W-1:0]   set_len     = DELAY_RESET;
    t_out_item           step_out [0:1];

    t_out_item           words_due [$];
    t_row                script [$];

    int unsigned         n_items     = 0;
    int unsigned         n_ticks     = 0;
    int unsigned         n_words     = 0;
    int unsigned         n_settings  = 0;
    int unsigned         n_errors    = 0;

    int unsigned         src_run     = 0;
    logic                src_quiet   = 1'b0;

    audio_playback_mode_stream_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        for (int i = 0; i < RING_DEPTH; i++) begin
            delay_ring[i] = '0;
        end
    end

    // Wait length for one request; quiet stretches keep a side busy back to back.
    function automatic int unsigned pick_wait(inout int unsigned run_left, inout logic quiet);
        if (run_left == 0) begin
            quiet    = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(16, 96);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, HOLD_MAX);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned ring_span();
        if (set_len == 0) return 1;
        if (set_len > RING_DEPTH) return RING_DEPTH;
        return set_len;
    endfunction

    function automatic logic [WORD_W-1:0] ring_read();
        if (ring_ptr >= RING_DEPTH) ring_ptr = 0;
        return delay_ring[ring_ptr];
    endfunction

    function automatic void ring_advance();
        ring_ptr = ring_ptr + 1;
        if (ring_ptr >= ring_span()) ring_ptr = 0;
    endfunction

    // Codec words caused by one request; fills step_out and returns the count.
    function automatic int unsigned playback_step(input t_in_item it);
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] held;
        step_out[0] = '0;
        step_out[1] = '0;
        if (it.func) begin
            if (ch_right) begin
                held = ring_read();
                ring_advance();
                ch_right = 1'b0;
                step_out[0].word = held;
            end else begin
                ch_right = 1'b1;
            end
            step_out[0].last = 1'b1;
            return 1;
        end
        w = {it.high_byte, it.low_byte};
        case (set_mode)
            MODE_DOUBLE: begin
                if (skip_next) begin
                    skip_next = 1'b0;
                    return 0;
                end
                skip_next = 1'b1;
                step_out[0] = '{word: w, last: 1'b1};
                return 1;
            end
            MODE_HALF: begin
                step_out[0] = '{word: w, last: 1'b0};
                step_out[1] = '{word: w, last: 1'b1};
                return 2;
            end
            MODE_DELAY: begin
                if (ch_right) begin
                    held = ring_read();
                    delay_ring[ring_ptr] = w;
                    ring_advance();
                    ch_right = 1'b0;
                    step_out[0] = '{word: held, last: 1'b1};
                end else begin
                    ch_right = 1'b1;
                    step_out[0] = '{word: w, last: 1'b1};
                end
                return 1;
            end
            default: begin
                step_out[0] = '{word: w, last: 1'b1};
                return 1;
            end
        endcase
    endfunction

    function automatic void add_row(input t_mode m, input logic [DLEN_W-1:0] d,
                                    input logic f, input logic [7:0] lo, input logic [7:0] hi,
                                    input logic known, input logic [1:0] n,
                                    input logic [WORD_W-1:0] w);
        t_row r;
        r.mode      = m;
        r.dlen      = d;
        r.item      = '{func: f, low_byte: lo, high_byte: hi};
        r.known     = known;
        r.n_words   = n;
        r.word      = w;
        script.push_back(r);
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned hold;
        hold = pick_wait(src_run, src_quiet);
        if (hold != 0) begin
            push <= 1'b0;
            repeat (hold) @(posedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full !== 1'b0);
        n_items++;
        if (it.func) n_ticks++;
    endtask

    // Hold the sender until every expected word is out, then let a dropped word drain.
    task automatic settle_idle();
        push <= 1'b0;
        do @(posedge i_clk); while (words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input t_mode m, input logic [DLEN_W-1:0] d);
        logic [DLEN_W-1:0] mode_data;
        settle_idle();
        mode_data      = DLEN_W'($urandom);
        mode_data[1:0] = m;     // upper bits of a mode write are ignored
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MODE;
        i_cfg_data  <= mode_data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_index <= CFG_DELAY_LENGTH;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        set_mode = m;
        set_len  = d;
        n_settings++;
    endtask

    initial begin : result_sink
        int unsigned hold;
        int unsigned sink_run;
        logic        sink_quiet;
        t_out_item   due;
        sink_run   = 0;
        sink_quiet = 1'b0;
        forever begin
            hold = pick_wait(sink_run, sink_quiet);
            if (hold != 0) begin
                pop <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0 || i_rst_n !== 1'b1);
            if (words_due.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected word, expected none, actual word %h last %b",
                         $time, o_out.word, o_out.last);
            end else begin
                due = words_due.pop_front();
                n_words++;
                if (o_out.word !== due.word) begin
                    n_errors++;
                    $display("%0t: word mismatch, expected %h, actual %h",
                             $time, due.word, o_out.word);
                end
                if (o_out.last !== due.last) begin
                    n_errors++;
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, due.last, o_out.last);
                end
            end
        end
    end

    initial begin : stimulus
        t_row        row;
        t_in_item    it;
        t_out_item   e;
        t_mode       m;
        logic [DLEN_W-1:0] d;
        int unsigned n;

        // Reset state and byte order first, then each mode, then the delay ring.
        add_row(MODE_NORMAL, DELAY_RESET, 1'b0, 8'h00, 8'h00, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_NORMAL, DELAY_RESET, 1'b0, 8'hFF, 8'hFF, 1'b1, 2'd1, 16'hFFFF);
        add_row(MODE_NORMAL, DELAY_RESET, 1'b0, 8'h34, 8'h12, 1'b1, 2'd1, 16'h1234);
        add_row(MODE_NORMAL, DELAY_RESET, 1'b1, 8'h77, 8'h66, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_NORMAL, DELAY_RESET, 1'b1, 8'h00, 8'h00, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_DOUBLE, DELAY_RESET, 1'b0, 8'h5A, 8'hA5, 1'b1, 2'd1, 16'hA55A);
        add_row(MODE_DOUBLE, DELAY_RESET, 1'b0, 8'h01, 8'h80, 1'b1, 2'd0, 16'h0000);
        add_row(MODE_DOUBLE, DELAY_RESET, 1'b0, 8'hFF, 8'h00, 1'b1, 2'd1, 16'h00FF);
        add_row(MODE_DOUBLE, DELAY_RESET, 1'b1, 8'hFF, 8'hFF, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_HALF,   DELAY_RESET, 1'b0, 8'h00, 8'hFF, 1'b1, 2'd2, 16'hFF00);
        add_row(MODE_HALF,   DELAY_RESET, 1'b0, 8'hAA, 8'h55, 1'b1, 2'd2, 16'h55AA);
        add_row(MODE_HALF,   DELAY_RESET, 1'b1, 8'h00, 8'h00, 1'b1, 2'd1, 16'h0000);
        // Shortened ring: the read still uses the old pointer, the advance wraps.
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h11, 8'h22, 1'b1, 2'd1, 16'h2211);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h33, 8'h44, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h00, 8'h00, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'hFF, 8'hFF, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h01, 8'h00, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h02, 8'h00, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h80, 8'h7F, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b0, 8'h03, 8'h00, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b1, 8'h00, 8'h00, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b1, 8'h00, 8'h00, 1'b0, 2'd0, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b1, 8'hFF, 8'hFF, 1'b1, 2'd1, 16'h0000);
        add_row(MODE_DELAY,  17'd2,       1'b1, 8'h00, 8'h00, 1'b0, 2'd0, 16'h0000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            row = script[k];
            if (row.mode != set_mode || row.dlen != set_len) begin
                apply_setting(row.mode, row.dlen);
            end
            send_item(row.item);
            n = playback_step(row.item);
            if (row.known) n = row.n_words;
            for (int j = 0; j < n; j++) begin
                if (row.known) begin
                    e.word = row.word;
                    e.last = (j == n - 1);
                end else begin
                    e = step_out[j];
                end
                words_due.push_back(e);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       begin m = MODE_NORMAL; d = 17'd1;       end
                1:       begin m = MODE_DOUBLE; d = 17'd3;       end
                2:       begin m = MODE_HALF;   d = 17'd0;       end
                3:       begin m = MODE_DELAY;  d = 17'd1;       end
                4:       begin m = MODE_DELAY;  d = 17'd0;       end
                5:       begin m = MODE_DELAY;  d = 17'd5;       end
                6:       begin m = MODE_DELAY;  d = 17'h1FFFF;   end
                7:       begin m = MODE_DELAY;  d = 17'd65536;   end
                8:       begin m = MODE_DOUBLE; d = 17'd2;       end
                9:       begin m = MODE_DELAY;  d = 17'd37;      end
                10:      begin m = MODE_HALF;   d = DELAY_RESET; end
                default: begin
                    m = t_mode'($urandom_range(0, 3));
                    d = DLEN_W'($urandom_range(1, 300));
                end
            endcase
            apply_setting(m, d);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                it.func      = (m == MODE_DELAY) ? ($urandom_range(0, 3) == 0)
                                                 : ($urandom_range(0, 9) == 0);
                it.low_byte  = pick_byte();
                it.high_byte = pick_byte();
                send_item(it);
                n = playback_step(it);
                for (int j = 0; j < n; j++) begin
                    words_due.push_back(step_out[j]);
                end
                if ($urandom_range(0, 199) == 0) settle_idle();
            end
        end

        settle_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d drain ticks) under %0d register settings",
                 n_items, n_ticks, n_settings);
        $display("Checked %0d codec words across all four modes, %0d errors",
                 n_words, n_errors);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Covers the ring clearing after reset and the slowest handshake pattern many times over.
    initial begin : watchdog
        #15_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
